// File: rtl/beat_peak_tempo_tracker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the beat peak tempo tracker
// Both macros expect clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef BEAT_PEAK_TEMPO_TRACKER_DEFINES_SVH
`define BEAT_PEAK_TEMPO_TRACKER_DEFINES_SVH

// same-cycle implication
`define BPTT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bptt_pkg.sv
// ----------------------------------------------------------------------------
// bptt_pkg
// Shared widths, constants, state encoding and control structs.
// ----------------------------------------------------------------------------
`default_nettype none
package bptt_pkg;

	localparam int PROB_W   = 16;
	localparam int NOW_W    = 31;
	localparam int TIME_W   = 32;
	localparam int TEMPO_W  = 16;
	localparam int OFS_W    = 11;
	localparam int IV_W     = 11;  // interval below 1500 ms
	localparam int IVL_W    = 34;  // full signed interval, never wraps
	localparam int TRIG_W   = 33;
	localparam int NUM_W    = 29;  // 4*tempo*interval + 15360000
	localparam int DEN_W    = 13;  // 5*interval
	localparam int CNT_W    = 5;

	localparam logic [PROB_W-1:0]     HALF_Q16        = 16'd32768;
	localparam logic signed [IVL_W-1:0] MIN_INTERVAL_MS = 34'sd300;
	localparam logic signed [IVL_W-1:0] MAX_INTERVAL_MS = 34'sd1500;
	localparam logic signed [TRIG_W-1:0] LOOKAHEAD_MS   = 33'sd50;
	localparam logic [NUM_W-1:0]      BPM_Q8_NUMERATOR = 29'd15360000;
	localparam logic [TEMPO_W-1:0]    TEMPO_RESET     = 16'd30720;
	localparam logic [CNT_W-1:0]      DIV_LAST        = CNT_W'(NUM_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic mul;
		logic div_step;
		logic load_out;
	} bptt_cmd_t;

	typedef struct packed {
		logic upd;
	} bptt_sts_t;

endpackage
`default_nettype wire

// File: rtl/bptt_ifs.sv
// ----------------------------------------------------------------------------
// bptt channel interfaces
// Valid/ready request channels for input frames and tracker results.
// ----------------------------------------------------------------------------
`default_nettype none
interface bptt_in_if import bptt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PROB_W-1:0]  frame_prob;
	logic [NOW_W-1:0]   now_ms;

	modport source (output valid, output frame_prob, output now_ms, input ready);
	modport sink   (input valid, input frame_prob, input now_ms, output ready);
endinterface

interface bptt_out_if import bptt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      beat_found;
	logic                      tempo_updated;
	logic signed [TIME_W-1:0]  beat_time_ms;
	logic [TEMPO_W-1:0]        tempo_q8;

	modport source (output valid, output beat_found, output tempo_updated,
		output beat_time_ms, output tempo_q8, input ready);
	modport sink   (input valid, input beat_found, input tempo_updated,
		input beat_time_ms, input tempo_q8, output ready);
endinterface
`default_nettype wire

// File: rtl/beat_peak_tempo_tracker.sv
// ----------------------------------------------------------------------------
// beat_peak_tempo_tracker
// Beat peak picking on a probability stream with smoothed tempo estimate.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one frame per request: frame_prob (Q0.16) and now_ms.
//   out_ch returns one result per frame: beat_found, tempo_updated, the
//   latest compensated trigger time and the Q8.8 tempo.
//   cfg_we/cfg_wdata write latency_offset_ms; write only while idle.
//   One frame is in work at a time. A frame that does not update the tempo
//   goes from accept through the evaluate state to the output register; one
//   that updates it also passes the multiply state and the 29-step serial
//   divider (one quotient bit a cycle) on the way. in_ch.ready is high again
//   the cycle after the result is loaded, so a new frame is accepted only
//   once the last one's result is in the output register.
//   The output register holds a result while out_ch.ready is low; the next
//   frame may be accepted and worked on meanwhile and waits at the end.
//   Reset clears the tracker: previous probability 0, last trigger 0,
//   tempo 120 BPM, offset 0, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none
module beat_peak_tempo_tracker import bptt_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	bptt_in_if.sink                       in_ch,
	bptt_out_if.source                    out_ch,
	input  wire logic                     cfg_we,
	input  wire logic signed [OFS_W-1:0]  cfg_wdata
);

	bptt_cmd_t cmd;
	bptt_sts_t sts;

	bptt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bptt_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.frame_prob    (in_ch.frame_prob),
		.now_ms        (in_ch.now_ms),
		.beat_found    (out_ch.beat_found),
		.tempo_updated (out_ch.tempo_updated),
		.beat_time_ms  (out_ch.beat_time_ms),
		.tempo_q8      (out_ch.tempo_q8)
	);

endmodule
`default_nettype wire

// File: rtl/bptt_datapath.sv
// ----------------------------------------------------------------------------
// bptt_datapath
// Peak test, trigger time, tempo multiply and serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module bptt_datapath import bptt_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire bptt_cmd_t                cmd,
	output bptt_sts_t                     sts,
	input  wire logic                     cfg_we,
	input  wire logic signed [OFS_W-1:0]  cfg_wdata,
	input  wire logic [PROB_W-1:0]        frame_prob,
	input  wire logic [NOW_W-1:0]         now_ms,
	output logic                          beat_found,
	output logic                          tempo_updated,
	output logic signed [TIME_W-1:0]      beat_time_ms,
	output logic [TEMPO_W-1:0]            tempo_q8
);

	// architectural state
	logic signed [OFS_W-1:0]  ofs_q;
	logic [PROB_W-1:0]        prev_prob_q;
	logic signed [TIME_W-1:0] last_trig_q;
	logic [TEMPO_W-1:0]       tempo_q;

	// per-item working registers
	logic [PROB_W-1:0]        prob_q;
	logic [NOW_W-1:0]         now_q;
	logic                     found_q;
	logic                     upd_q;
	logic [IV_W-1:0]          iv_q;
	logic [NUM_W-1:0]         quo_q;
	logic [DEN_W-1:0]         rem_q;
	logic [DEN_W-1:0]         den_q;

	logic signed [IVL_W-1:0]  interval;
	logic signed [TRIG_W-1:0] trig;
	logic signed [TIME_W-1:0] trig_sat;
	logic                     rise;
	logic                     fire;
	logic                     upd;
	logic [DEN_W:0]           trial;
	logic                     trial_ge;
	logic [TEMPO_W-1:0]       tempo_new;

	always_comb begin
		interval = $signed({3'b000, now_q}) - IVL_W'(last_trig_q);
		trig     = $signed({2'b00, now_q}) - LOOKAHEAD_MS - TRIG_W'(ofs_q);
		rise     = (prob_q > HALF_Q16) && (prev_prob_q <= HALF_Q16);
		fire     = rise && (interval > MIN_INTERVAL_MS);
		upd      = fire && (interval < MAX_INTERVAL_MS);
		// saturate to the signed 32-bit range
		if (trig[TRIG_W-1] != trig[TRIG_W-2])
			trig_sat = trig[TRIG_W-1] ? {1'b1, {(TIME_W-1){1'b0}}}
				: {1'b0, {(TIME_W-1){1'b1}}};
		else
			trig_sat = trig[TIME_W-1:0];
		trial    = {rem_q, quo_q[NUM_W-1]};
		trial_ge = trial >= {1'b0, den_q};
		tempo_new = (quo_q > NUM_W'({TEMPO_W{1'b1}})) ? {TEMPO_W{1'b1}}
			: quo_q[TEMPO_W-1:0];
	end

	assign sts.upd = upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q       <= '0;
			prev_prob_q <= '0;
			last_trig_q <= '0;
			tempo_q     <= TEMPO_RESET;
		end else begin
			if (cfg_we)
				ofs_q <= cfg_wdata;
			if (cmd.eval) begin
				prev_prob_q <= prob_q;
				if (fire)
					last_trig_q <= trig_sat;
			end
			if (cmd.load_out && upd_q)
				tempo_q <= tempo_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			prob_q <= frame_prob;
			now_q  <= now_ms;
		end
		if (cmd.eval) begin
			found_q <= fire;
			upd_q   <= upd;
			iv_q    <= interval[IV_W-1:0];
		end
		if (cmd.mul) begin
			// full 27-bit product, then times four
			quo_q <= NUM_W'({(TEMPO_W+IV_W)'(tempo_q) * (TEMPO_W+IV_W)'(iv_q), 2'b00})
				+ BPM_Q8_NUMERATOR;
			den_q <= DEN_W'({iv_q, 2'b00}) + DEN_W'(iv_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			// one restoring step, quotient bit shifts in behind the numerator
			rem_q <= trial_ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], trial_ge};
		end
		if (cmd.load_out) begin
			beat_found    <= found_q;
			tempo_updated <= upd_q;
			beat_time_ms  <= last_trig_q;
			tempo_q8      <= upd_q ? tempo_new : tempo_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/bptt_ctrl.sv
// ----------------------------------------------------------------------------
// bptt_ctrl
// Sequencer for one frame: evaluate, multiply and divide on a tempo update, hand over result.
// ----------------------------------------------------------------------------
`default_nettype none
module bptt_ctrl import bptt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire bptt_sts_t  sts,
	output bptt_cmd_t       cmd
);

	ctrl_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mul)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.upd ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/bptt_checker.sv
// ----------------------------------------------------------------------------
// bptt_checker
// Port-level checks on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "beat_peak_tempo_tracker_defines.svh"
module bptt_checker import bptt_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic                     beat_found,
	input wire logic                     tempo_updated,
	input wire logic signed [TIME_W-1:0] beat_time_ms,
	input wire logic [TEMPO_W-1:0]       tempo_q8
);

	`BPTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(beat_time_ms) && $stable(tempo_q8), "result dropped or changed while stalled")
	`BPTT_ASSERT_IMPL(a_upd_needs_beat, out_valid, !tempo_updated || beat_found, "tempo update without a beat")
	`BPTT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second frame taken while one is in work")

endmodule

bind beat_peak_tempo_tracker bptt_checker u_bptt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.beat_found    (out_ch.beat_found),
	.tempo_updated (out_ch.tempo_updated),
	.beat_time_ms  (out_ch.beat_time_ms),
	.tempo_q8      (out_ch.tempo_q8)
);
`default_nettype wire
